>>> sv/mbr_pkg.sv
// Package for the MSB-first bit reader: request/response structs, action
// codes and the internal command kinds passed from front to back.
// No dependencies.
`default_nettype none

package mbr_pkg;

   // Default store size in bytes
   localparam int unsigned STORE_DEPTH_DEF = 4096;

   // Field widths fixed by the interface
   localparam int unsigned VALUE_W    = 64;
   localparam int unsigned BYTE_POS_W = 13;
   localparam int unsigned MAX_BITS   = 64;

   // Request action codes
   localparam logic [2:0] ACT_APPEND    = 3'd0;
   localparam logic [2:0] ACT_READ_BITS = 3'd1;
   localparam logic [2:0] ACT_UNARY     = 3'd2;
   localparam logic [2:0] ACT_READ_BYTE = 3'd3;
   localparam logic [2:0] ACT_REWIND    = 3'd4;

   // Command kinds after classification
   typedef enum logic [2:0] {
      CMD_APPEND,
      CMD_READ_BITS,
      CMD_UNARY,
      CMD_READ_BYTE,
      CMD_REWIND,
      CMD_NONE
   } cmd_kind_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] load_value;
      logic [6:0] bit_count;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]    value;
      logic [BYTE_POS_W-1:0] byte_position;
      logic [2:0]            bit_position;
      logic [2:0]            align_bits;
      logic                  end_of_stream;
      logic                  truncated;
      logic                  store_full;
   } rsp_type;

   // One classified request waiting in the queue
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   load_value;
      logic [6:0]   bit_count;
   } queue_entry_type;

endpackage

`default_nettype wire

>>> sv/msb_first_bit_reader_unit.sv
// Top level of the MSB-first bit reader: front end with request queue and
// back end with byte store. Uses mbr_pkg, mbr_front and mbr_back.
//
// Usage:
//   Requests enter on req_item when start is high and busy is low. busy is
//   high only while the two-entry request queue is full.
//   Each request produces exactly one response, shown on rsp_item for one
//   cycle with rsp_valid high. The receiver cannot hold responses off.
//   Handling once a request reaches the head of the queue (the cycle after
//   it is taken when the queue is empty):
//     append, rewind, unknown action: response next cycle, one per cycle
//     read byte: through the use state, which takes the byte from the store
//     read bits: a use step for each byte the field touches (at most 9
//       bytes)
//     read unary: a use step for each byte scanned to find the one
//   The back end reads one byte of the store per cycle through its single
//   read port; that port sets the cost of bit and unary reads.
//   Reset clears the stream (no bytes loaded), the read position and the
//   queue, and sets end of stream. The store needs no clearing pass.
`default_nettype none

module msb_first_bit_reader_unit #(
   parameter int unsigned STORE_DEPTH = mbr_pkg::STORE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire mbr_pkg::req_type req_item,
   output logic                  busy,
   output logic                  rsp_valid,
   output mbr_pkg::rsp_type      rsp_item
);

   logic                     q_valid;
   logic                     q_pop;
   mbr_pkg::queue_entry_type q_entry;

   // Accept and classify
   mbr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop)
   );

   // Execute against the byte store
   mbr_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

>>> sv/mbr_front.sv
// Front end of the bit reader: accepts requests, classifies the action and
// holds them in a two-entry queue for the back end. Uses mbr_pkg.
`default_nettype none

module mbr_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire mbr_pkg::req_type        req_item,
   output logic                         busy,
   output logic                         q_valid,
   output mbr_pkg::queue_entry_type     q_entry,
   input  wire logic                    q_pop
);

   mbr_pkg::queue_entry_type entry_ff [2];
   logic                     wr_ptr_ff, wr_ptr_in;
   logic                     rd_ptr_ff, rd_ptr_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic                     push;
   mbr_pkg::queue_entry_type new_entry;

   // Classify the action
   always_comb begin
      new_entry.load_value = req_item.load_value;
      new_entry.bit_count  = req_item.bit_count;
      unique case (req_item.action)
         mbr_pkg::ACT_APPEND:    new_entry.kind = mbr_pkg::CMD_APPEND;
         mbr_pkg::ACT_READ_BITS: new_entry.kind = mbr_pkg::CMD_READ_BITS;
         mbr_pkg::ACT_UNARY:     new_entry.kind = mbr_pkg::CMD_UNARY;
         mbr_pkg::ACT_READ_BYTE: new_entry.kind = mbr_pkg::CMD_READ_BYTE;
         mbr_pkg::ACT_REWIND:    new_entry.kind = mbr_pkg::CMD_REWIND;
         default:                new_entry.kind = mbr_pkg::CMD_NONE;
      endcase
   end

   // Queue occupancy and pointers
   assign busy    = cnt_ff[1];
   assign push    = start & ~busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

`default_nettype wire

>>> sv/mbr_back.sv
// Back end of the bit reader: byte store, read position and the sequencer
// that walks the store one byte per cycle. Uses mbr_pkg.
`default_nettype none

module mbr_back #(
   parameter int unsigned STORE_DEPTH = mbr_pkg::STORE_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   input  wire mbr_pkg::queue_entry_type q_entry,
   output logic                         q_pop,
   output logic                         rsp_valid,
   output mbr_pkg::rsp_type             rsp_item
);

   localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
   localparam int unsigned AW = $clog2(STORE_DEPTH);
   localparam int unsigned PW = CW + 3;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_USE  = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   mbr_pkg::cmd_kind_type kind_ff, kind_in;
   logic [CW-1:0]         loaded_ff, loaded_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [2:0]            off_ff, off_in;
   logic                  end_ff, end_in;
   logic [6:0]            rem_ff, rem_in;
   logic [63:0]           val_ff, val_in;
   logic                  trunc_ff, trunc_in;
   logic                  full_in;
   logic                  fin;
   logic                  wr_en;

   logic [7:0]            store_ff [0:STORE_DEPTH-1];
   logic [7:0]            rd_data_ff;

   logic                  rsp_valid_ff;
   mbr_pkg::rsp_type      rsp_item_ff;

   // Position arithmetic
   logic [PW-1:0]         left_bits;
   logic [PW-1:0]         cnt_ext;
   logic                  cut;
   logic [6:0]            n_cut;
   logic [CW-1:0]         idx_inc;
   logic                  at_last;
   logic                  have_byte;

   // Field extraction from the current byte
   logic [3:0]            avail;
   logic [3:0]            take;
   logic [3:0]            shamt;
   logic [8:0]            field_mask;
   logic [7:0]            field_bits;
   logic [3:0]            off_sum;

   // Unary scan of the current byte
   logic [7:0]            live;
   logic                  found;
   logic [2:0]            one_pos;
   logic [3:0]            one_next;

   logic [CW+12:0]        idx_wide;

   assign left_bits = {loaded_ff, 3'b000} - {idx_ff, off_ff};
   assign cnt_ext   = {{(PW-7){1'b0}}, q_entry.bit_count};
   assign cut       = (cnt_ext > left_bits);
   assign n_cut     = cut ? left_bits[6:0] : q_entry.bit_count;
   assign idx_inc   = idx_ff + CW'(1);
   assign at_last   = (idx_inc == loaded_ff);
   assign have_byte = (idx_ff < loaded_ff);

   assign avail      = 4'd8 - {1'b0, off_ff};
   assign take       = (rem_ff < {3'b000, avail}) ? rem_ff[3:0] : avail;
   assign shamt      = avail - take;
   assign field_mask = (9'd1 << take) - 9'd1;
   assign field_bits = (rd_data_ff >> shamt) & field_mask[7:0];
   assign off_sum    = {1'b0, off_ff} + take;

   assign live     = rd_data_ff & (8'hFF >> off_ff);
   assign found    = |live;
   assign one_next = {1'b0, one_pos} + 4'd1;

   // First one from the most significant bit
   always_comb begin
      one_pos = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (live[i]) begin
            one_pos = 3'(7 - i);
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      loaded_in = loaded_ff;
      idx_in    = idx_ff;
      off_in    = off_ff;
      end_in    = end_ff;
      rem_in    = rem_ff;
      val_in    = val_ff;
      trunc_in  = trunc_ff;
      full_in   = 1'b0;
      fin       = 1'b0;
      wr_en     = 1'b0;
      q_pop     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               kind_in  = q_entry.kind;
               val_in   = 64'd0;
               trunc_in = 1'b0;
               rem_in   = n_cut;
               unique case (q_entry.kind)
                  mbr_pkg::CMD_APPEND: begin
                     fin = 1'b1;
                     if (loaded_ff < CW'(STORE_DEPTH)) begin
                        wr_en     = 1'b1;
                        loaded_in = loaded_ff + CW'(1);
                        end_in    = 1'b0;
                     end else begin
                        full_in = 1'b1;
                     end
                  end
                  mbr_pkg::CMD_READ_BITS: begin
                     if (end_ff) begin
                        val_in = '1;
                        fin    = 1'b1;
                     end else begin
                        if (cut) begin
                           end_in   = 1'b1;
                           trunc_in = 1'b1;
                        end
                        if (n_cut > 7'(mbr_pkg::MAX_BITS)) begin
                           val_in = '1;
                           fin    = 1'b1;
                        end else if (n_cut == 7'd0) begin
                           fin = 1'b1;
                        end else begin
                           state_in = ST_USE;
                        end
                     end
                  end
                  mbr_pkg::CMD_UNARY: begin
                     if (end_ff) begin
                        val_in = '1;
                        fin    = 1'b1;
                     end else if (left_bits == '0) begin
                        end_in   = 1'b1;
                        trunc_in = 1'b1;
                        fin      = 1'b1;
                     end else begin
                        state_in = ST_USE;
                     end
                  end
                  mbr_pkg::CMD_READ_BYTE: begin
                     if (end_ff) begin
                        val_in = '1;
                        fin    = 1'b1;
                     end else if (have_byte) begin
                        state_in = ST_USE;
                     end else begin
                        val_in   = '1;
                        end_in   = 1'b1;
                        trunc_in = 1'b1;
                        fin      = 1'b1;
                     end
                  end
                  mbr_pkg::CMD_REWIND: begin
                     idx_in = '0;
                     off_in = 3'd0;
                     end_in = 1'b0;
                     fin    = 1'b1;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_USE: begin
            unique case (kind_ff)
               mbr_pkg::CMD_READ_BITS: begin
                  // Take up to the rest of this byte
                  val_in = (val_ff << take) | {56'd0, field_bits};
                  rem_in = rem_ff - {3'b000, take};
                  if (off_sum[3]) begin
                     idx_in = idx_inc;
                     off_in = 3'd0;
                  end else begin
                     off_in = off_sum[2:0];
                  end
                  if (rem_ff == {3'b000, take}) begin
                     fin      = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               mbr_pkg::CMD_UNARY: begin
                  if (found) begin
                     // Zeros up to the one, then step past it
                     val_in = val_ff + 64'(one_pos - off_ff);
                     if (one_next[3]) begin
                        idx_in = idx_inc;
                        off_in = 3'd0;
                     end else begin
                        off_in = one_next[2:0];
                     end
                     fin      = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     val_in = val_ff + 64'(avail);
                     idx_in = idx_inc;
                     off_in = 3'd0;
                     if (at_last) begin
                        end_in   = 1'b1;
                        trunc_in = 1'b1;
                        fin      = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end
               end
               default: begin
                  // Whole byte read; bit offset is kept
                  val_in   = {56'd0, rd_data_ff};
                  idx_in   = idx_inc;
                  end_in   = at_last;
                  fin      = 1'b1;
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         loaded_ff <= '0;
         idx_ff    <= '0;
         off_ff    <= 3'd0;
         end_ff    <= 1'b1;
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
         idx_ff    <= idx_in;
         off_ff    <= off_in;
         end_ff    <= end_in;
      end
   end

   // Per-command working registers
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      rem_ff   <= rem_in;
      val_ff   <= val_in;
      trunc_ff <= trunc_in;
   end

   // Byte store: one write port, one registered read at the next position
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[loaded_ff[AW-1:0]] <= q_entry.load_value;
      end
      rd_data_ff <= store_ff[idx_in[AW-1:0]];
   end

   // Response register
   assign idx_wide = {13'd0, idx_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_item_ff.value         <= val_in;
         rsp_item_ff.byte_position <= idx_wide[12:0];
         rsp_item_ff.bit_position  <= off_in;
         rsp_item_ff.align_bits    <= (off_in == 3'd0) ? 3'd0 : 3'(4'd8 - {1'b0, off_in});
         rsp_item_ff.end_of_stream <= end_in;
         rsp_item_ff.truncated     <= trunc_in;
         rsp_item_ff.store_full    <= full_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

>>> sv/mbr_checker.sv
// Port-level checks for the MSB-first bit reader, bound to the top level.
// Uses mbr_pkg and msb_first_bit_reader_unit.
`default_nettype none

module mbr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire mbr_pkg::req_type req_item,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire mbr_pkg::rsp_type rsp_item
);

   // Nothing pending right after a reset edge
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("response or busy right after reset");

   // Queue can only fill after a request was taken
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   // A cut-short read always leaves end of stream set
   a_trunc_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.truncated) |-> rsp_item.end_of_stream)
      else $error("truncated without end of stream");

   // A dropped append returns nothing else
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.store_full) |->
         (rsp_item.value == 64'd0 && !rsp_item.truncated))
      else $error("store full with other status");

   // Alignment distance matches the bit position
   a_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_item.bit_position == 3'd0 && rsp_item.align_bits == 3'd0) ||
          (rsp_item.bit_position != 3'd0 &&
           rsp_item.align_bits == 3'(4'd8 - {1'b0, rsp_item.bit_position}))))
      else $error("align_bits does not match bit_position");

endmodule

bind msb_first_bit_reader_unit mbr_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/mbr_stream_checker.sv
// Response checker for the MSB-first bit reader: mirrors the byte store and
// read position, predicts each response and compares it with the DUT's.
// Depends on mbr_pkg for the request/response structs and action codes.
module mbr_stream_checker #(
   parameter int unsigned DEPTH = mbr_pkg::STORE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  mbr_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  mbr_pkg::rsp_type rsp_item,
   output int unsigned      pending_count,
   output int unsigned      checked_count,
   output int unsigned      fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Mirror of the reader state
   logic [7:0]  mirror_bytes [DEPTH];
   int unsigned bytes_held  = 0;
   int unsigned rd_byte     = 0;
   logic [2:0]  rd_bit      = '0;
   logic        stream_done = 1'b1;

   // Predicted responses, oldest first
   mbr_pkg::rsp_type owed_rsp_q [$];

   initial begin
      pending_count = 0;
      checked_count = 0;
      fail_count    = 0;
   end

   task automatic note_failure(input string msg);
      fail_count++;
      $display("[%0t] response %0d: %s", $time, checked_count, msg);
   endtask

   function automatic int unsigned bits_remaining();
      int unsigned total;
      int unsigned used;
      total = bytes_held * 8;
      used  = rd_byte * 8 + rd_bit;
      return (total > used) ? total - used : 0;
   endfunction

   // Take the bit under the read position and step past it
   function automatic logic pull_bit();
      logic b;
      b = 1'b0;
      if (rd_byte < bytes_held) b = mirror_bytes[rd_byte][3'd7 - rd_bit];
      if (rd_bit == 3'd7) rd_byte++;
      rd_bit++;   // wraps to zero at the byte boundary
      return b;
   endfunction

   // Apply one request to the mirror and build the response it should give
   function automatic mbr_pkg::rsp_type advance_reader(input mbr_pkg::req_type r);
      mbr_pkg::rsp_type o;
      logic [63:0]      field;
      int unsigned      want;
      o     = '0;
      field = '0;
      case (r.action)
         mbr_pkg::ACT_APPEND: begin
            if (bytes_held < DEPTH) begin
               mirror_bytes[bytes_held] = r.load_value;
               bytes_held++;
               stream_done = 1'b0;
            end else begin
               o.store_full = 1'b1;
            end
         end
         // Short streams cut the count; anything wider than 64 gives all ones
         mbr_pkg::ACT_READ_BITS: begin
            if (stream_done) begin
               field = '1;
            end else begin
               want = r.bit_count;
               if (want > bits_remaining()) begin
                  want        = bits_remaining();
                  stream_done = 1'b1;
                  o.truncated = 1'b1;
               end
               if (want > mbr_pkg::MAX_BITS) begin
                  field = '1;
               end else begin
                  for (int i = 0; i < want; i++) field = {field[62:0], pull_bit()};
               end
            end
         end
         // Count zeros up to a one; running out returns the count so far
         mbr_pkg::ACT_UNARY: begin
            if (stream_done) begin
               field = '1;
            end else begin
               while (1) begin
                  if (bits_remaining() == 0) begin
                     stream_done = 1'b1;
                     o.truncated = 1'b1;
                     break;
                  end
                  if (pull_bit()) break;
                  field++;
               end
            end
         end
         // Whole byte at the byte index, bit offset left alone
         mbr_pkg::ACT_READ_BYTE: begin
            if (stream_done) begin
               field = '1;
            end else if (rd_byte < bytes_held) begin
               field = {56'd0, mirror_bytes[rd_byte]};
               rd_byte++;
               if (rd_byte == bytes_held) stream_done = 1'b1;
            end else begin
               stream_done = 1'b1;
               o.truncated = 1'b1;
               field       = '1;
            end
         end
         mbr_pkg::ACT_REWIND: begin
            rd_byte     = 0;
            rd_bit      = '0;
            stream_done = 1'b0;
         end
         default: ;
      endcase
      o.value         = field;
      o.byte_position = mbr_pkg::BYTE_POS_W'(rd_byte);
      o.bit_position  = rd_bit;
      o.align_bits    = (rd_bit == 3'd0) ? 3'd0 : 3'(4'd8 - {1'b0, rd_bit});
      o.end_of_stream = stream_done;
      return o;
   endfunction

   // Check responses first, then log the request taken at this edge
   always @(posedge clock) begin
      mbr_pkg::rsp_type due;
      if (reset) begin
         bytes_held  = 0;
         rd_byte     = 0;
         rd_bit      = '0;
         stream_done = 1'b1;
         owed_rsp_q.delete();
      end else begin
         if (rsp_valid) begin
            if (owed_rsp_q.size() == 0) begin
               note_failure("response with no request outstanding");
            end else begin
               due = owed_rsp_q.pop_front();
               if (rsp_item.value !== due.value)
                  note_failure($sformatf("value %h, expected %h",
                                         rsp_item.value, due.value));
               if (rsp_item.byte_position !== due.byte_position)
                  note_failure($sformatf("byte_position %0d, expected %0d",
                                         rsp_item.byte_position, due.byte_position));
               if (rsp_item.bit_position !== due.bit_position)
                  note_failure($sformatf("bit_position %0d, expected %0d",
                                         rsp_item.bit_position, due.bit_position));
               if (rsp_item.align_bits !== due.align_bits)
                  note_failure($sformatf("align_bits %0d, expected %0d",
                                         rsp_item.align_bits, due.align_bits));
               if (rsp_item.end_of_stream !== due.end_of_stream)
                  note_failure($sformatf("end_of_stream %b, expected %b",
                                         rsp_item.end_of_stream, due.end_of_stream));
               if (rsp_item.truncated !== due.truncated)
                  note_failure($sformatf("truncated %b, expected %b",
                                         rsp_item.truncated, due.truncated));
               if (rsp_item.store_full !== due.store_full)
                  note_failure($sformatf("store_full %b, expected %b",
                                         rsp_item.store_full, due.store_full));
               checked_count++;
            end
         end
         if (start && !busy) owed_rsp_q.push_back(advance_reader(req_item));
      end
      pending_count = owed_rsp_q.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// Top of the MSB-first bit reader testbench: clock, reset and request stimulus
// for msb_first_bit_reader_unit, with mbr_stream_checker judging the responses.
// Depends on mbr_pkg, msb_first_bit_reader_unit and mbr_stream_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH        = mbr_pkg::STORE_DEPTH_DEF;
   localparam int unsigned RANDOM_ITEMS = 800;
   localparam int unsigned COUNT_MAX    = 127;
   // Action codes the block does not define
   localparam logic [2:0]  ACT_SPARE_FIRST = mbr_pkg::ACT_REWIND + 3'd1;
   localparam logic [2:0]  ACT_SPARE_LAST  = 3'd7;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   mbr_pkg::req_type req_item = '0;
   logic             busy;
   logic             rsp_valid;
   mbr_pkg::rsp_type rsp_item;
   int unsigned      pending_count;
   int unsigned      checked_count;
   int unsigned      fail_count;

   // Sender burst state and request tallies
   int unsigned burst_left   = 0;
   int unsigned bytes_sent   = 0;
   int unsigned reads_sent   = 0;
   int unsigned rewinds_sent = 0;
   int unsigned spares_sent  = 0;

   msb_first_bit_reader_unit #(.STORE_DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   mbr_stream_checker #(.DEPTH(DEPTH)) stream_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .fail_count    (fail_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hang guard
   initial begin
      #10ms;
      $display("timeout with %0d responses outstanding", pending_count);
      $display("msb_first_bit_reader_unit regression: fail");
      $finish;
   end

   // Drive one request at the falling edge, hold it until taken
   task automatic issue(input logic [2:0] act, input logic [7:0] load, input logic [6:0] nbits);
      int unsigned      gap;
      mbr_pkg::req_type r;
      if (burst_left == 0) begin
         // new burst: mostly short, now and then a long unbroken run
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      r.action     = act;
      r.load_value = load;
      r.bit_count  = nbits;
      @(negedge clock);
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      case (act) inside
         mbr_pkg::ACT_APPEND: bytes_sent++;
         mbr_pkg::ACT_REWIND: rewinds_sent++;
         mbr_pkg::ACT_READ_BITS, mbr_pkg::ACT_UNARY, mbr_pkg::ACT_READ_BYTE: reads_sent++;
         default:             spares_sent++;
      endcase
   endtask

   // Unused fields carry random bits so every input bit toggles
   task automatic send_append(input logic [7:0] b);
      issue(mbr_pkg::ACT_APPEND, b, 7'($urandom));
   endtask

   task automatic send_bits(input logic [6:0] n);
      issue(mbr_pkg::ACT_READ_BITS, 8'($urandom), n);
   endtask

   task automatic send_unary();
      issue(mbr_pkg::ACT_UNARY, 8'($urandom), 7'($urandom));
   endtask

   task automatic send_byte_read();
      issue(mbr_pkg::ACT_READ_BYTE, 8'($urandom), 7'($urandom));
   endtask

   task automatic send_rewind();
      issue(mbr_pkg::ACT_REWIND, 8'($urandom), 7'($urandom));
   endtask

   task automatic random_read();
      case ($urandom_range(0, 9)) inside
         0, 1, 2: send_bits(7'($urandom_range(1, mbr_pkg::MAX_BITS)));
         3, 4:    send_bits(7'($urandom_range(1, 8)));
         5, 6:    send_unary();
         default: send_byte_read();
      endcase
   endtask

   // Stop sending until every response is back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      logic [7:0]  seed_bytes [9];
      int unsigned first;
      int unsigned kind;
      bit          zero_heavy;
      bit          paused;

      seed_bytes = '{8'h00, 8'h00, 8'h01, 8'hFF, 8'hA5,
                     8'h5A, 8'h80, 8'h7F, 8'hC3};
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty stream after reset, end flag already set
      send_bits(7'd8);
      send_unary();
      send_byte_read();
      send_rewind();          // clears the flag even with nothing loaded
      send_bits(7'd1);        // nothing left: cut to zero bits, value 0
      send_rewind();
      send_unary();           // unary with no bits at all
      send_rewind();
      send_byte_read();       // byte index already at the length
      foreach (seed_bytes[i]) send_append(seed_bytes[i]);
      send_bits(7'd0);        // zero-length read
      send_bits(7'd1);
      send_bits(7'd100);      // cut to 71 bits, still wider than 64
      send_rewind();
      send_unary();           // 23 zeros before the first one
      send_byte_read();
      send_bits(7'(mbr_pkg::MAX_BITS)); // cut short at the end of the stream
      issue(ACT_SPARE_FIRST, 8'($urandom), 7'($urandom));
      issue(ACT_SPARE_LAST, 8'($urandom), 7'($urandom));

      // Random: mostly appends followed by reads, plus rewinds and odd requests
      paused = 1'b0;
      first  = bytes_sent + reads_sent + rewinds_sent;
      while (bytes_sent + reads_sent + rewinds_sent - first < RANDOM_ITEMS) begin
         if (!paused && bytes_sent + reads_sent + rewinds_sent - first >= RANDOM_ITEMS / 2)
         begin
            drain();
            paused = 1'b1;
         end
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            zero_heavy = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 12)) begin
               send_append((zero_heavy && $urandom_range(0, 2) != 0) ? 8'h00 : 8'($urandom));
            end
            repeat ($urandom_range(1, 10)) random_read();
         end else if (kind <= 7) begin
            send_rewind();
            repeat ($urandom_range(1, 8)) random_read();
         end else if (kind == 8) begin
            case ($urandom_range(0, 3))
               0: issue(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)),
                        8'($urandom), 7'($urandom));
               1: send_bits(7'd0);
               2: send_bits(7'($urandom_range(mbr_pkg::MAX_BITS + 1, COUNT_MAX)));
               default: send_bits(7'($urandom));
            endcase
         end else begin
            // read through to the end and keep reading there
            repeat ($urandom_range(8, 40)) random_read();
         end
      end

      // Let everything in flight come back
      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d appends, %0d reads, %0d rewinds and %0d undefined actions",
               bytes_sent, reads_sent, rewinds_sent, spares_sent);
      $display("in bursts with gaps and one full drain; %0d responses checked",
               checked_count);
      if (fail_count == 0) begin
         $display("msb_first_bit_reader_unit regression: pass");
      end else begin
         $display("msb_first_bit_reader_unit regression: fail");
      end
      $finish;
   end

endmodule

>>> msb_first_bit_reader_unit.f
sv/mbr_pkg.sv
sv/mbr_front.sv
sv/mbr_back.sv
sv/msb_first_bit_reader_unit.sv
sv/mbr_checker.sv
tb/sv/mbr_stream_checker.sv
tb/sv/tb_top.sv
